@@ sv/mfm_sector_stream_decoder_assert.svh @@
// Assertion macros for the MFM sector stream decoder.
`ifndef MFM_SECTOR_STREAM_DECODER_ASSERT_SVH
`define MFM_SECTOR_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define MFMD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mfmd check failed");

// Next-cycle implication.
`define MFMD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mfmd check failed");

`endif

@@ sv/mfmd_pkg.sv @@
// Types, constants and helpers shared by the MFM sector stream decoder.
package mfmd_pkg;

	localparam int DATA_LONGS = 128;
	localparam int IDX_W      = $clog2(DATA_LONGS);
	localparam int SKIP_LONGS = 12;
	localparam int INFO_W     = 24;

	localparam logic [31:0] SYNC_LONG = 32'h4489_4489;
	localparam logic [31:0] DATA_MASK = 32'h5555_5555;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);

	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_FILTER_ENABLE = 2'd0;
	localparam logic [1:0] REG_WANTED_SECTOR = 2'd1;
	localparam logic [1:0] REG_MAX_SECTORS   = 2'd2;
	localparam logic [4:0] MAX_SECTORS_RESET = 5'd11;

	typedef struct packed {
		logic [31:0] mfm_word;
		logic        end_of_track;
	} item_t;

	typedef struct packed {
		logic [31:0] data_word;
		logic [6:0]  word_index;
		logic [7:0]  sector_number;
		logic [7:0]  track_number;
		logic [7:0]  format_byte;
		logic        last_of_sector;
		logic        status;
	} result_t;

	typedef struct packed {
		logic       filter_enable;
		logic [7:0] wanted_sector;
		logic [4:0] max_sectors;
	} cfg_t;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_DATA   = 2'd1,
		CMD_STATUS = 2'd2
	} cmd_op_t;

	// info holds decoded header bits 31..8: format, track, sector
	typedef struct packed {
		cmd_op_t            op;
		logic [31:0]        word;
		logic [IDX_W-1:0]   idx;
		logic [INFO_W-1:0]  info;
		logic               last;
	} cmd_t;

	function automatic logic [31:0] join_odd_even(input logic [31:0] odd,
			input logic [31:0] even);
		return ((odd & DATA_MASK) << 1) | (even & DATA_MASK);
	endfunction

endpackage

@@ sv/mfm_sector_stream_decoder.sv @@
// MFM sector stream decoder: one raw longword per item.
// Throughput: one item per cycle unless full; commands pass a 4-entry command queue.
// Path of a result: command queue write, then the odd store read stage, then a write
// into the 4-entry result queue; data and status commands wait while it has no room.
// Reset (arst_n low, asynchronous): hunting for sync, queues empty, registers to reset
// values; the 128-entry odd store is not cleared, every read follows a write.
module mfm_sector_stream_decoder
	import mfmd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  item_t              item,
	output logic               empty,
	input  logic               pop,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t cfg_q;
	logic accept;
	logic cmd_push;
	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cmd_empty;
	logic cmd_pop;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_enable <= 1'b0;
			cfg_q.wanted_sector <= '0;
			cfg_q.max_sectors   <= MAX_SECTORS_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_FILTER_ENABLE: cfg_q.filter_enable <= pwdata[0];
				REG_WANTED_SECTOR: cfg_q.wanted_sector <= pwdata[7:0];
				REG_MAX_SECTORS:   cfg_q.max_sectors   <= pwdata[4:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FILTER_ENABLE: prdata = {31'd0, cfg_q.filter_enable};
			REG_WANTED_SECTOR: prdata = {24'd0, cfg_q.wanted_sector};
			REG_MAX_SECTORS:   prdata = {27'd0, cfg_q.max_sectors};
			default:           prdata = '0;
		endcase
	end

	mfmd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.cfg      (cfg_q),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	mfmd_cmd_queue u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd_in),
		.full     (full),
		.pop      (cmd_pop),
		.head     (cmd_head),
		.empty    (cmd_empty)
	);

	mfmd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

@@ sv/mfmd_front.sv @@
// Front end: sync hunt, header decode and sector sequencing into commands.
module mfmd_front
	import mfmd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  item_t item,
	input  cfg_t  cfg,
	output logic  cmd_push,
	output cmd_t  cmd
);

	typedef enum logic [6:0] {
		PH_HUNT     = 7'b0000001,
		PH_HDR_ODD  = 7'b0000010,
		PH_HDR_EVEN = 7'b0000100,
		PH_SKIP     = 7'b0001000,
		PH_DATA_ODD = 7'b0010000,
		PH_DATA_EVN = 7'b0100000,
		PH_DONE     = 7'b1000000
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [IDX_W-1:0]  pos_q, pos_d;
	logic [4:0]        done_q, done_d;
	logic              sel_q, sel_d;
	logic [31:0]       hdr_odd_q, hdr_odd_d;
	logic [INFO_W-1:0] info_q, info_d;
	logic [31:0]       hdr_full;
	logic [4:0]        limit;
	logic [4:0]        done_inc;
	logic              eot;
	logic              pos_last;

	assign eot      = item.end_of_track;
	assign hdr_full = join_odd_even(hdr_odd_q, item.mfm_word);
	assign limit    = (cfg.max_sectors == 5'd0) ? 5'd1 : cfg.max_sectors;
	assign done_inc = done_q + 5'd1;
	assign pos_last = (pos_q == IDX_W'(DATA_LONGS - 1));

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		done_d    = done_q;
		sel_d     = sel_q;
		hdr_odd_d = hdr_odd_q;
		info_d    = info_q;
		cmd_push  = 1'b0;
		cmd.op    = CMD_STATUS;
		cmd.word  = '0;
		cmd.idx   = '0;
		cmd.info  = info_q;
		cmd.last  = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (!eot && item.mfm_word == SYNC_LONG)
					phase_d = PH_HDR_ODD;
			end
			PH_HDR_ODD: begin
				hdr_odd_d = item.mfm_word;
				if (eot) begin
					cmd_push = 1'b1;
					cmd.info = '0;
				end else begin
					phase_d = PH_HDR_EVEN;
				end
			end
			PH_HDR_EVEN: begin
				info_d   = hdr_full[31:8];
				sel_d    = !cfg.filter_enable || (hdr_full[15:8] == cfg.wanted_sector);
				pos_d    = '0;
				phase_d  = PH_SKIP;
				cmd.info = hdr_full[31:8];
				cmd_push = eot;
			end
			PH_SKIP: begin
				if (pos_q == IDX_W'(SKIP_LONGS - 1)) begin
					pos_d   = '0;
					phase_d = PH_DATA_ODD;
				end else begin
					pos_d = pos_q + 1'b1;
				end
				cmd_push = eot;
			end
			PH_DATA_ODD: begin
				// a track end abandons the sector, so its odd word need not be stored
				cmd_push = 1'b1;
				if (!eot) begin
					cmd.op   = CMD_WRITE;
					cmd.word = item.mfm_word;
					cmd.idx  = pos_q;
				end
				if (pos_last) begin
					pos_d   = '0;
					phase_d = PH_DATA_EVN;
				end else begin
					pos_d = pos_q + 1'b1;
				end
			end
			PH_DATA_EVN: begin
				if (pos_last) begin
					cmd_push = sel_q;
					cmd.op   = CMD_DATA;
					cmd.word = item.mfm_word;
					cmd.idx  = pos_q;
					cmd.last = 1'b1;
					done_d   = done_inc;
					pos_d    = '0;
					phase_d  = (done_inc >= limit) ? PH_DONE : PH_HUNT;
				end else if (eot) begin
					cmd_push = 1'b1;
				end else begin
					cmd_push = sel_q;
					cmd.op   = CMD_DATA;
					cmd.word = item.mfm_word;
					cmd.idx  = pos_q;
					pos_d    = pos_q + 1'b1;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		if (eot) begin
			phase_d = PH_HUNT;
			pos_d   = '0;
			done_d  = '0;
		end
		cmd_push = cmd_push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			pos_q     <= '0;
			done_q    <= '0;
			sel_q     <= 1'b0;
			hdr_odd_q <= '0;
			info_q    <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			pos_q     <= pos_d;
			done_q    <= done_d;
			sel_q     <= sel_d;
			hdr_odd_q <= hdr_odd_d;
			info_q    <= info_d;
		end
	end

endmodule

@@ sv/mfmd_cmd_queue.sv @@
// Short command queue between the front end and the back end.
module mfmd_cmd_queue
	import mfmd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t head,
	output logic empty
);

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_q, rd_q;
	logic [CMDQ_PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ sv/mfmd_back.sv @@
// Back end: odd data store, odd/even join and the result queue.
module mfmd_back
	import mfmd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cmd_t    cmd,
	input  logic    cmd_empty,
	output logic    cmd_pop,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	`include "mfm_sector_stream_decoder_assert.svh"

	logic [31:0]           odd_mem [DATA_LONGS];
	logic [31:0]           odd_s1;
	logic                  valid_s1;
	cmd_op_t               op_s1;
	logic [31:0]           word_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [INFO_W-1:0]     info_s1;
	logic                  last_s1;

	result_t               outq_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] owr_q, ord_q;
	logic [OUTQ_PTR_W:0]   ocnt_q;
	logic [OUTQ_PTR_W:0]   committed;
	logic                  room;
	logic                  is_write;
	logic                  out_pop;
	result_t               res_s1;

	// results in flight count against the queue before a command is taken
	assign committed = ocnt_q + (OUTQ_PTR_W+1)'(valid_s1);
	assign room      = (committed < (OUTQ_PTR_W+1)'(OUTQ_DEPTH));
	assign is_write  = (cmd.op == CMD_WRITE);
	assign cmd_pop   = !cmd_empty && (is_write || room);
	assign out_pop   = pop && !empty;
	assign empty     = (ocnt_q == '0);
	assign result    = outq_q[ord_q];

	always_ff @(posedge clk) begin
		if (cmd_pop && is_write)
			odd_mem[cmd.idx] <= cmd.word;
		if (cmd_pop && cmd.op == CMD_DATA)
			odd_s1 <= odd_mem[cmd.idx];
		if (cmd_pop) begin
			op_s1   <= cmd.op;
			word_s1 <= cmd.word;
			idx_s1  <= cmd.idx;
			info_s1 <= cmd.info;
			last_s1 <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= cmd_pop && !is_write;
	end

	always_comb begin
		res_s1.data_word      = (op_s1 == CMD_DATA) ? join_odd_even(odd_s1, word_s1) : '0;
		res_s1.word_index     = 7'(idx_s1);
		res_s1.sector_number  = info_s1[7:0];
		res_s1.track_number   = info_s1[15:8];
		res_s1.format_byte    = info_s1[23:16];
		res_s1.last_of_sector = last_s1;
		res_s1.status         = (op_s1 == CMD_STATUS);
	end

	always_ff @(posedge clk) begin
		if (valid_s1)
			outq_q[owr_q] <= res_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (valid_s1)
				owr_q <= owr_q + 1'b1;
			if (out_pop)
				ord_q <= ord_q + 1'b1;
			case ({valid_s1, out_pop})
				2'b10:   ocnt_q <= ocnt_q + 1'b1;
				2'b01:   ocnt_q <= ocnt_q - 1'b1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	`MFMD_ASSERT_NOW(a_outq_no_overflow, valid_s1 && !out_pop,
		ocnt_q < (OUTQ_PTR_W+1)'(OUTQ_DEPTH))
	`MFMD_ASSERT_NEXT(a_emit_reaches_s1, cmd_pop && !is_write, valid_s1)
	`MFMD_ASSERT_NOW(a_credit_bound, 1'b1, committed <= (OUTQ_PTR_W+1)'(OUTQ_DEPTH))

endmodule
